@@ hw/rtl/bounded_ordered_list_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef BOUNDED_ORDERED_LIST_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BOL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded_ordered_list: check failed");

// Next-cycle implication, disabled while in reset.
`define BOL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded_ordered_list: check failed");

`endif

@@ hw/rtl/bol_pkg.sv @@
`timescale 1ns / 1ps

package bol_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Transaction field widths
  localparam int OP_W     = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 4;
  localparam int LEN_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_DEL_VAL  = 3'd2,
    OP_DEL_POS  = 3'd3,
    OP_READ_FWD = 3'd4,
    OP_READ_REV = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

endpackage

@@ hw/rtl/bol_if.sv @@
`timescale 1ns / 1ps

interface bol_in_if;
  import bol_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] item_value;
  logic [POS_W-1:0]        position;

  modport source (output valid, op, item_value, position, input ready);
  modport sink (input valid, op, item_value, position, output ready);
  modport monitor (input valid, ready, op, item_value, position);
endinterface

interface bol_out_if;
  import bol_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] read_value;
  logic [IDX_W-1:0]        read_index;
  logic                    last;
  logic [LEN_W-1:0]        list_length;

  modport source (output valid, status, read_value, read_index, last, list_length,
                  input ready);
  modport sink (input valid, status, read_value, read_index, last, list_length,
                output ready);
  modport monitor (input valid, ready, status, read_value, read_index, last,
                   list_length);
endinterface

@@ hw/rtl/bounded_ordered_list.sv @@
`timescale 1ns / 1ps
// Bounded ordered list of signed 32-bit values, up to 16 entries.
// in_ch carries one command per transaction (append, insert at position,
// delete by value, delete at position, read forward, read reverse).
// out_ch returns one result per write command, one per entry for a read
// (last marks the final one), or a single status for an empty list.
// Unused op codes are consumed and give no result.
// Entries live in a single-port-write, single-port-read RAM, and every
// move goes through that one read/write pair under a small sequencer,
// so in_ch.ready is high only while no command is in progress.
// A rejected command moves no entries. An append or insert at p moves each
// entry from p to the tail up by one; a delete at p moves each entry above
// p down by one; a delete by value first scans from the head for a match,
// then closes the gap the same way; a read fetches each entry in turn.
// A stalled out_ch holds its transaction and pauses the sequencer at the
// next result; it never drops or repeats one.
// Synchronous reset empties the list and clears out_ch.valid; RAM contents
// are left as they are, since only entries below the count are ever read.
module bounded_ordered_list (
  input  logic      clk,
  input  logic      rst_n,
  bol_in_if.sink    in_ch,
  bol_out_if.source out_ch
);
  import bol_pkg::*;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic signed [VAL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic signed [VAL_W-1:0] ram_rdata;

  bol_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  bol_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ hw/rtl/bol_ram.sv @@
`timescale 1ns / 1ps

module bol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bol_seq.sv @@
`timescale 1ns / 1ps

module bol_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  bol_in_if.sink                           in_ch,
  bol_out_if.source                        out_ch,
  output logic                             ram_we,
  output logic [bol_pkg::ADDR_W-1:0]       ram_waddr,
  output logic signed [bol_pkg::VAL_W-1:0] ram_wdata,
  output logic [bol_pkg::ADDR_W-1:0]       ram_raddr,
  input  logic signed [bol_pkg::VAL_W-1:0] ram_rdata
);
  import bol_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DISP     = 12'b0000_0000_0010,
    S_FETCH    = 12'b0000_0000_0100,
    S_SRCH_RD  = 12'b0000_0000_1000,
    S_SRCH_CMP = 12'b0000_0001_0000,
    S_UP_RD    = 12'b0000_0010_0000,
    S_UP_WR    = 12'b0000_0100_0000,
    S_DN_RD    = 12'b0000_1000_0000,
    S_DN_WR    = 12'b0001_0000_0000,
    S_RD_ADDR  = 12'b0010_0000_0000,
    S_RD_DATA  = 12'b0100_0000_0000,
    S_EMIT     = 12'b1000_0000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  status_t                 res_status_r, res_status_nxt;
  logic signed [VAL_W-1:0] res_val_r, res_val_nxt;
  logic [IDX_W-1:0]        res_idx_r, res_idx_nxt;
  logic                    res_last_r, res_last_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic                    out_last_r;
  logic [LEN_W-1:0]        out_len_r;

  logic                    out_free;
  logic                    out_load;
  logic [CNT_W-1:0]        ptr_inc;
  logic [CNT_W-1:0]        ptr_dec;
  logic [CNT_W-1:0]        rd_idx;
  logic [POS_W-1:0]        ins_pos;

  assign out_free = !out_valid_r || out_ch.ready;
  assign ptr_inc  = ptr_r + 1'b1;
  assign ptr_dec  = ptr_r - 1'b1;
  assign rd_idx   = (op_r == OP_READ_FWD) ? ptr_r : (cnt_r - 1'b1 - ptr_r);
  // An empty list or an append always places the value at the tail
  assign ins_pos  = (op_r == OP_APPEND || cnt_r == '0) ? POS_W'(cnt_r) : pos_r;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    res_idx_nxt    = res_idx_r;
    res_last_nxt   = res_last_r;
    out_load       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r[ADDR_W-1:0];
    ram_wdata      = ram_rdata;
    ram_raddr      = ptr_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = op_t'(in_ch.op);
          val_nxt   = in_ch.item_value;
          pos_nxt   = in_ch.position;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        // Default to a rejected transaction; overridden below on success
        res_val_nxt  = '0;
        res_idx_nxt  = '0;
        res_last_nxt = 1'b1;
        ptr_nxt      = '0;
        ram_raddr    = pos_r[ADDR_W-1:0];
        case (op_r)
          OP_APPEND, OP_INSERT: begin
            if (cnt_r >= CNT_W'(CAPACITY)) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_EMIT;
            end else if (ins_pos > POS_W'(cnt_r)) begin
              res_status_nxt = ST_BADPOS;
              state_nxt      = S_EMIT;
            end else begin
              pos_nxt        = ins_pos;
              ptr_nxt        = cnt_r;
              res_status_nxt = ST_OK;
              res_val_nxt    = val_r;
              res_idx_nxt    = IDX_W'(ins_pos);
              state_nxt      = S_UP_RD;
            end
          end
          OP_DEL_VAL: begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_SRCH_RD;
            end
          end
          OP_DEL_POS: begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_EMIT;
            end else if (pos_r >= POS_W'(cnt_r)) begin
              res_status_nxt = ST_BADPOS;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_FETCH;
            end
          end
          OP_READ_FWD, OP_READ_REV: begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_EMIT;
            end else begin
              state_nxt = S_RD_ADDR;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_FETCH: begin
        res_status_nxt = ST_OK;
        res_val_nxt    = ram_rdata;
        res_idx_nxt    = IDX_W'(pos_r);
        res_last_nxt   = 1'b1;
        ptr_nxt        = CNT_W'(pos_r);
        state_nxt      = S_DN_RD;
      end

      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        if (ram_rdata == val_r) begin
          res_status_nxt = ST_OK;
          res_val_nxt    = val_r;
          res_idx_nxt    = IDX_W'(ptr_r);
          state_nxt      = S_DN_RD;
        end else if (ptr_inc == cnt_r) begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_EMIT;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_SRCH_RD;
        end
      end

      // Close the gap: entry[k] <= entry[k+1] up to the tail
      S_DN_RD: begin
        ram_raddr = ptr_inc[ADDR_W-1:0];
        if (ptr_inc < cnt_r) begin
          state_nxt = S_DN_WR;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_EMIT;
        end
      end

      S_DN_WR: begin
        ram_we    = 1'b1;
        ptr_nxt   = ptr_inc;
        state_nxt = S_DN_RD;
      end

      // Open a slot: entry[k] <= entry[k-1] from the tail down to the slot
      S_UP_RD: begin
        ram_raddr = ptr_dec[ADDR_W-1:0];
        if (POS_W'(ptr_r) > pos_r) begin
          state_nxt = S_UP_WR;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = val_r;
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_EMIT;
        end
      end

      S_UP_WR: begin
        ram_we    = 1'b1;
        ptr_nxt   = ptr_dec;
        state_nxt = S_UP_RD;
      end

      S_RD_ADDR: begin
        ram_raddr = rd_idx[ADDR_W-1:0];
        state_nxt = S_RD_DATA;
      end

      S_RD_DATA: begin
        res_status_nxt = ST_OK;
        res_val_nxt    = ram_rdata;
        res_idx_nxt    = IDX_W'(rd_idx);
        res_last_nxt   = (ptr_inc == cnt_r);
        state_nxt      = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (res_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_inc;
            state_nxt = S_RD_ADDR;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    ptr_r        <= ptr_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    res_idx_r    <= res_idx_nxt;
    res_last_r   <= res_last_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_val_r    <= res_val_r;
      out_idx_r    <= res_idx_r;
      out_last_r   <= res_last_r;
      out_len_r    <= LEN_W'(cnt_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.read_value  = out_val_r;
  assign out_ch.read_index  = out_idx_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.list_length = out_len_r;

endmodule

@@ hw/rtl/bol_checker.sv @@
`timescale 1ns / 1ps
`include "bounded_ordered_list_defines.svh"

module bol_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [bol_pkg::STATUS_W-1:0]        out_status,
  input logic signed [bol_pkg::VAL_W-1:0]    out_read_value,
  input logic [bol_pkg::IDX_W-1:0]           out_read_index,
  input logic                                out_last,
  input logic [bol_pkg::LEN_W-1:0]           out_list_length
);
  import bol_pkg::*;

  logic                                  in_acc;
  logic                                  out_stall;
  logic                                  out_reject;
  logic                                  reject_clean;
  logic                                  out_empty;
  logic [STATUS_W+VAL_W+IDX_W+LEN_W:0]   out_payload;

  assign in_acc       = in_valid && in_ready;
  assign out_stall    = out_valid && !out_ready;
  assign out_reject   = out_valid && (out_status != ST_OK);
  assign reject_clean = (out_read_value == '0) && (out_read_index == '0) && out_last;
  assign out_empty    = out_valid && (out_status == ST_EMPTY);
  assign out_payload  = {out_status, out_read_value, out_read_index, out_last, out_list_length};

  // One command at a time: ready drops right after a command is taken
  `BOL_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ready)

  // Rejected or empty results carry a zeroed value and index and end the command
  `BOL_ASSERT_IMP(a_reject_fields, clk, rst_n, out_reject, reject_clean)

  `BOL_ASSERT_IMP(a_len_bound, clk, rst_n, out_valid, out_list_length <= LEN_W'(CAPACITY))

  `BOL_ASSERT_IMP(a_empty_len, clk, rst_n, out_empty, out_list_length == '0)

  `BOL_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_payload))

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_read_value  (out_ch.read_value),
  .out_read_index  (out_ch.read_index),
  .out_last        (out_ch.last),
  .out_list_length (out_ch.list_length)
);
